/* rtl/core/tlprs_pkg.sv */
package tlprs_pkg;

  // Fixed field widths
  localparam int unsigned TIDW = 5;   // task identifier
  localparam int unsigned PRW  = 8;   // priority
  localparam int unsigned BW   = 16;  // burst
  localparam int unsigned WW   = 32;  // wait / time

  localparam logic [7:0] QUANTUM_RESET = 8'd4;

  // Operation codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_IDLE_TCK = 2'd2;

  // Running level codes
  localparam logic [1:0] LVL_IDLE = 2'd0;
  localparam logic [1:0] LVL_PRIO = 2'd1;
  localparam logic [1:0] LVL_RR   = 2'd2;

  // Per-task record held in the task memory
  typedef struct packed {
    logic [PRW-1:0] prio;
    logic [BW-1:0]  remain;
    logic [BW-1:0]  orig;
    logic [WW-1:0]  wait_cnt;
    logic [WW-1:0]  arrival;
  } task_rec_t;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_RESOLVE = 7'b0000010,
    S_PICK    = 7'b0000100,
    S_POP     = 7'b0001000,
    S_POP2    = 7'b0010000,
    S_SERVE   = 7'b0100000,
    S_FINAL   = 7'b1000000
  } state_e;

endpackage

/* rtl/core/two_level_priority_rr_scheduler_core.sv */
// Channel   | Ports                                             | Handshake
// ----------+---------------------------------------------------+---------------------------
// command   | operation_i task_id_i task_priority_i task_burst_i | start, busy
// result    | status_o running_id_o ... current_time_o           | done_o, one-cycle strobe
// config    | cfg_wdata_i                                        | cfg_we_i, no wait
//
// An arrive item is taken without leaving idle; its result strobes on the next cycle.
// A tick item keeps busy high while it places new arrivals, then searches level one or
// pops the FIFO head if nothing runs, sweeps the tasks and reports; with none pending it
// skips the sweep. Each sweep reads one task-memory entry per cycle, then drains the read.
// rst_ni clears control state but run_prio_q and best_prio_q; the memories need no clearing.
// Results cannot be stalled; busy is high while a tick is in progress.
module two_level_priority_rr_scheduler_core #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        operation_i,
  input  logic [4:0]  task_id_i,
  input  logic [7:0]  task_priority_i,
  input  logic [15:0] task_burst_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [4:0]  running_id_o,
  output logic [1:0]  running_level_o,
  output logic        finished_o,
  output logic [4:0]  finished_id_o,
  output logic [31:0] finished_wait_o,
  output logic [31:0] finished_turnaround_o,
  output logic [31:0] current_time_o
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned TIDW = tlprs_pkg::TIDW;

  // Control state
  tlprs_pkg::state_e state_q, state_d;
  logic [MAX_TASKS-1:0] member_q, member_d;
  logic [MAX_TASKS-1:0] fmask_q, fmask_d;
  logic [IW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [TIDW-1:0] run_q, run_d;
  logic [1:0]      lvl_q, lvl_d;
  logic [7:0]      run_prio_q, run_prio_d;
  logic [7:0]      slice_q, slice_d;
  logic [31:0]     tick_q, tick_d;
  logic [TIDW-1:0] best_q, best_d;
  logic [7:0]      best_prio_q, best_prio_d;
  logic [7:0]      quantum_q;

  // Sweep state
  logic [CW-1:0]   sc_q, sc_d;
  logic            pv_q, pv_d;
  logic [IW-1:0]   pidx_q, pidx_d;
  logic            cv_q, cv_d;
  logic [TIDW-1:0] cid_q, cid_d;
  logic [7:0]      cprio_q, cprio_d;
  logic [31:0]     carr_q, carr_d;
  logic            fin_q, fin_d;
  logic [31:0]     fwait_q, fwait_d;
  logic [15:0]     forig_q, forig_d;

  // Result register
  logic        done_q, done_d;
  logic [1:0]  status_q, status_d;
  logic [4:0]  rid_q, rid_d;
  logic [1:0]  rlvl_q, rlvl_d;
  logic        rfin_q, rfin_d;
  logic [4:0]  rfid_q, rfid_d;
  logic [31:0] rfw_q, rfw_d;
  logic [31:0] rft_q, rft_d;
  logic [31:0] rtime_q, rtime_d;

  // Memories
  tlprs_pkg::task_rec_t tmem [MAX_TASKS];
  tlprs_pkg::task_rec_t trd_q;
  tlprs_pkg::task_rec_t twdata;
  logic                 twe;
  logic [IW-1:0]        twaddr, traddr;
  logic [TIDW-1:0]      fmem [MAX_TASKS];
  logic [TIDW-1:0]      frd_q;
  logic                 fwe;
  logic [TIDW-1:0]      fwdata;

  logic [IW-1:0]  run_idx, arr_idx, tail;
  logic [CW:0]    tail_sum;
  logic           accept, reject, better, is_run;
  logic [32:0]    turn_sum;
  logic [7:0]     slice_inc;

  assign busy    = (state_q != tlprs_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign run_idx = IW'(run_q - TIDW'(1));
  assign arr_idx = IW'(task_id_i - TIDW'(1));
  assign traddr  = (sc_q < CW'(MAX_TASKS)) ? sc_q[IW-1:0] : '0;

  // FIFO tail position
  assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
  assign tail = (tail_sum >= (CW+1)'(MAX_TASKS)) ? IW'(tail_sum - (CW+1)'(MAX_TASKS))
                                                : IW'(tail_sum);
  assign fwdata = run_q;

  // Arrival check
  assign reject = (task_id_i == '0) || (32'(task_id_i) > MAX_TASKS) || (task_burst_i == '0) ||
                  member_q[arr_idx] || fmask_q[arr_idx] ||
                  ((lvl_q == tlprs_pkg::LVL_RR) && (run_q == task_id_i));

  // Shared comparator: lower priority, then earlier arrival
  assign better = !cv_q || (trd_q.prio < cprio_q) ||
                  ((trd_q.prio == cprio_q) && (trd_q.arrival < carr_q));
  assign is_run = (lvl_q != tlprs_pkg::LVL_IDLE) && (pidx_q == run_idx);

  assign turn_sum  = {1'b0, fwait_q} + 33'(forig_q);
  assign slice_inc = slice_q + 8'd1;

  always_comb begin
    state_d = state_q;
    member_d = member_q;
    fmask_d = fmask_q;
    head_d = head_q;
    count_d = count_q;
    run_d = run_q;
    lvl_d = lvl_q;
    run_prio_d = run_prio_q;
    slice_d = slice_q;
    tick_d = tick_q;
    best_d = best_q;
    best_prio_d = best_prio_q;
    sc_d = sc_q;
    pv_d = 1'b0;
    pidx_d = pidx_q;
    cv_d = cv_q;
    cid_d = cid_q;
    cprio_d = cprio_q;
    carr_d = carr_q;
    fin_d = fin_q;
    fwait_d = fwait_q;
    forig_d = forig_q;
    done_d = 1'b0;
    status_d = status_q;
    rid_d = rid_q;
    rlvl_d = rlvl_q;
    rfin_d = rfin_q;
    rfid_d = rfid_q;
    rfw_d = rfw_q;
    rft_d = rft_q;
    rtime_d = rtime_q;
    twe = 1'b0;
    twaddr = arr_idx;
    twdata = trd_q;
    fwe = 1'b0;

    // Sweep issue, shared by the pick and serve passes
    if (sc_q < CW'(MAX_TASKS)) begin
      pv_d = (state_q == tlprs_pkg::S_PICK) || (state_q == tlprs_pkg::S_SERVE);
      pidx_d = sc_q[IW-1:0];
      if (pv_d) begin
        sc_d = sc_q + CW'(1);
      end
    end

    unique case (state_q)
      tlprs_pkg::S_IDLE: begin
        if (accept && operation_i == tlprs_pkg::OP_ARRIVE) begin
          done_d = 1'b1;
          status_d = reject ? tlprs_pkg::ST_REJECT : tlprs_pkg::ST_OK;
          rid_d = run_q;
          rlvl_d = lvl_q;
          rfin_d = 1'b0;
          rfid_d = '0;
          rfw_d = '0;
          rft_d = '0;
          rtime_d = tick_q;
          if (!reject) begin
            twe = 1'b1;
            twdata.prio = task_priority_i;
            twdata.remain = task_burst_i;
            twdata.orig = task_burst_i;
            twdata.wait_cnt = '0;
            twdata.arrival = tick_q;
            member_d[arr_idx] = 1'b1;
            if (best_q == '0 || task_priority_i < best_prio_q) begin
              best_d = task_id_i;
              best_prio_d = task_priority_i;
            end
          end
        end else if (accept) begin
          state_d = tlprs_pkg::S_RESOLVE;
        end
      end

      // Place the best new arrival, else choose how to find a task to run
      tlprs_pkg::S_RESOLVE: begin
        if (best_q != '0) begin
          if (lvl_q == tlprs_pkg::LVL_RR) begin
            fwe = 1'b1;
            fmask_d[run_idx] = 1'b1;
            count_d = count_q + CW'(1);
            run_d = best_q;
            lvl_d = tlprs_pkg::LVL_PRIO;
            run_prio_d = best_prio_q;
            slice_d = '0;
          end else if (lvl_q == tlprs_pkg::LVL_PRIO) begin
            if (best_prio_q < run_prio_q) begin
              fwe = 1'b1;
              member_d[run_idx] = 1'b0;
              fmask_d[run_idx] = 1'b1;
              count_d = count_q + CW'(1);
              run_d = best_q;
              run_prio_d = best_prio_q;
            end
          end else begin
            run_d = best_q;
            lvl_d = tlprs_pkg::LVL_PRIO;
            run_prio_d = best_prio_q;
          end
          best_d = '0;
          state_d = tlprs_pkg::S_SERVE;
        end else if (lvl_q != tlprs_pkg::LVL_IDLE) begin
          state_d = tlprs_pkg::S_SERVE;
        end else if (member_q != '0) begin
          state_d = tlprs_pkg::S_PICK;
        end else if (count_q != '0) begin
          state_d = tlprs_pkg::S_POP;
        end else begin
          state_d = tlprs_pkg::S_FINAL;
        end
        sc_d = '0;
        cv_d = 1'b0;
        fin_d = 1'b0;
      end

      // Search level one for the next task
      tlprs_pkg::S_PICK: begin
        if (pv_q && member_q[pidx_q] && better) begin
          cv_d = 1'b1;
          cid_d = TIDW'(pidx_q) + TIDW'(1);
          cprio_d = trd_q.prio;
          carr_d = trd_q.arrival;
        end
        if (!pv_q && sc_q == CW'(MAX_TASKS)) begin
          run_d = cid_q;
          run_prio_d = cprio_q;
          lvl_d = tlprs_pkg::LVL_PRIO;
          sc_d = '0;
          cv_d = 1'b0;
          state_d = tlprs_pkg::S_SERVE;
        end
      end

      tlprs_pkg::S_POP: begin
        state_d = tlprs_pkg::S_POP2;
      end

      // Take the FIFO head
      tlprs_pkg::S_POP2: begin
        run_d = frd_q;
        lvl_d = tlprs_pkg::LVL_RR;
        slice_d = '0;
        fmask_d[IW'(frd_q - TIDW'(1))] = 1'b0;
        head_d = (head_q == IW'(MAX_TASKS - 1)) ? '0 : head_q + IW'(1);
        count_d = count_q - CW'(1);
        state_d = tlprs_pkg::S_SERVE;
      end

      // Age waiting tasks, serve the running one, find its successor
      tlprs_pkg::S_SERVE: begin
        if (pv_q) begin
          twaddr = pidx_q;
          if (is_run) begin
            twe = 1'b1;
            twdata.remain = trd_q.remain - 16'd1;
            if (trd_q.remain == 16'd1) begin
              fin_d = 1'b1;
              fwait_d = trd_q.wait_cnt;
              forig_d = trd_q.orig;
            end
          end else if (member_q[pidx_q] || fmask_q[pidx_q]) begin
            twe = 1'b1;
            if (trd_q.wait_cnt != '1) begin
              twdata.wait_cnt = trd_q.wait_cnt + 32'd1;
            end
          end
          if (member_q[pidx_q] && !is_run && better) begin
            cv_d = 1'b1;
            cid_d = TIDW'(pidx_q) + TIDW'(1);
            cprio_d = trd_q.prio;
            carr_d = trd_q.arrival;
          end
        end
        if (!pv_q && sc_q == CW'(MAX_TASKS)) begin
          state_d = tlprs_pkg::S_FINAL;
        end
      end

      // Report, advance time, retire a finished task or requeue an expired round-robin task
      tlprs_pkg::S_FINAL: begin
        done_d = 1'b1;
        tick_d = tick_q + 32'd1;
        rtime_d = tick_q + 32'd1;
        rfin_d = 1'b0;
        rfid_d = '0;
        rfw_d = '0;
        rft_d = '0;
        state_d = tlprs_pkg::S_IDLE;
        if (lvl_q == tlprs_pkg::LVL_IDLE) begin
          status_d = tlprs_pkg::ST_IDLE_TCK;
          rid_d = '0;
          rlvl_d = tlprs_pkg::LVL_IDLE;
        end else begin
          status_d = tlprs_pkg::ST_OK;
          rid_d = run_q;
          rlvl_d = lvl_q;
          if (fin_q) begin
            rfin_d = 1'b1;
            rfid_d = run_q;
            rfw_d = fwait_q;
            rft_d = turn_sum[32] ? '1 : turn_sum[31:0];
            slice_d = '0;
            if (lvl_q == tlprs_pkg::LVL_PRIO) begin
              member_d[run_idx] = 1'b0;
              run_d = cv_q ? cid_q : '0;
              run_prio_d = cprio_q;
              lvl_d = cv_q ? tlprs_pkg::LVL_PRIO : tlprs_pkg::LVL_IDLE;
            end else begin
              run_d = '0;
              lvl_d = tlprs_pkg::LVL_IDLE;
            end
          end else if (lvl_q == tlprs_pkg::LVL_RR) begin
            slice_d = slice_inc;
            if (slice_inc >= quantum_q) begin
              fwe = 1'b1;
              fmask_d[run_idx] = 1'b1;
              count_d = count_q + CW'(1);
              run_d = '0;
              lvl_d = tlprs_pkg::LVL_IDLE;
              slice_d = '0;
            end
          end
        end
      end

      default: begin
        state_d = tlprs_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlprs_pkg::S_IDLE;
      member_q <= '0;
      fmask_q <= '0;
      head_q <= '0;
      count_q <= '0;
      run_q <= '0;
      lvl_q <= tlprs_pkg::LVL_IDLE;
      slice_q <= '0;
      tick_q <= '0;
      best_q <= '0;
      quantum_q <= tlprs_pkg::QUANTUM_RESET;
      sc_q <= '0;
      pv_q <= 1'b0;
      cv_q <= 1'b0;
      fin_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      member_q <= member_d;
      fmask_q <= fmask_d;
      head_q <= head_d;
      count_q <= count_d;
      run_q <= run_d;
      lvl_q <= lvl_d;
      slice_q <= slice_d;
      tick_q <= tick_d;
      best_q <= best_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
      sc_q <= sc_d;
      pv_q <= pv_d;
      cv_q <= cv_d;
      fin_q <= fin_d;
      done_q <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    run_prio_q <= run_prio_d;
    best_prio_q <= best_prio_d;
    pidx_q <= pidx_d;
    cid_q <= cid_d;
    cprio_q <= cprio_d;
    carr_q <= carr_d;
    fwait_q <= fwait_d;
    forig_q <= forig_d;
    status_q <= status_d;
    rid_q <= rid_d;
    rlvl_q <= rlvl_d;
    rfin_q <= rfin_d;
    rfid_q <= rfid_d;
    rfw_q <= rfw_d;
    rft_q <= rft_d;
    rtime_q <= rtime_d;
  end

  // Task memory
  always_ff @(posedge clk_i) begin
    if (twe) begin
      tmem[twaddr] <= twdata;
    end
    trd_q <= tmem[traddr];
  end

  // Round-robin FIFO memory
  always_ff @(posedge clk_i) begin
    if (fwe) begin
      fmem[tail] <= fwdata;
    end
    frd_q <= fmem[head_q];
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign running_id_o = rid_q;
  assign running_level_o = rlvl_q;
  assign finished_o = rfin_q;
  assign finished_id_o = rfid_q;
  assign finished_wait_o = rfw_q;
  assign finished_turnaround_o = rft_q;
  assign current_time_o = rtime_q;

`ifndef SYNTHESIS
  a_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (member_q & fmask_q) == '0) else $error("task both in level one and FIFO");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(fmask_q) == 32'(count_q)) else $error("FIFO count mismatch");
  a_rr_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_q == tlprs_pkg::LVL_RR) |-> !member_q[run_idx] && !fmask_q[run_idx])
    else $error("round-robin task still queued");
  a_prio_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_q == tlprs_pkg::LVL_PRIO) |-> member_q[run_idx])
    else $error("level-one task not a member");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NTASK = 16;

  // Scheduler result as seen on the result ports
  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  run_id;
    logic [1:0]  run_lvl;
    logic        fin;
    logic [4:0]  fin_id;
    logic [31:0] fin_wait;
    logic [31:0] fin_turn;
    logic [31:0] now;
  } sched_result_t;

  // One directed item; a fixed status is typed in where it is obvious
  typedef struct packed {
    logic        op;
    logic [4:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic        fixed;
    logic [1:0]  status;
  } directed_item_t;

  logic        clk_i, rst_ni;
  logic        start, busy;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        operation_i;
  logic [4:0]  task_id_i;
  logic [7:0]  task_priority_i;
  logic [15:0] task_burst_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [4:0]  running_id_o;
  logic [1:0]  running_level_o;
  logic        finished_o;
  logic [4:0]  finished_id_o;
  logic [31:0] finished_wait_o;
  logic [31:0] finished_turnaround_o;
  logic [31:0] current_time_o;

  two_level_priority_rr_scheduler_core #(.MAX_TASKS(NTASK)) u_top (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_wdata_i,
    .operation_i, .task_id_i, .task_priority_i, .task_burst_i,
    .done_o, .status_o, .running_id_o, .running_level_o, .finished_o,
    .finished_id_o, .finished_wait_o, .finished_turnaround_o, .current_time_o
  );

  // Scheduler shadow state
  logic [7:0]  s_prio   [NTASK];
  logic [15:0] s_remain [NTASK];
  logic [15:0] s_orig   [NTASK];
  logic [31:0] s_wait   [NTASK];
  logic [31:0] s_arr    [NTASK];
  logic [4:0]  s_fifo   [NTASK];
  logic [NTASK-1:0] s_l1;
  int unsigned s_head, s_cnt, s_run, s_lvl, s_slice, s_best;
  logic [31:0] s_now;
  logic [7:0]  s_quantum;

  sched_result_t pending_results[$];
  int fails = 0;
  int n_items = 0, n_results = 0, n_finished = 0, n_rejects = 0;
  bit gaps_on = 1;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit queued_rr(int unsigned id);
    for (int k = 0; k < s_cnt; k++)
      if (s_fifo[(s_head + k) % NTASK] == id) return 1;
    return 0;
  endfunction

  task automatic rr_push(int unsigned id);
    if (s_cnt < NTASK) begin
      s_fifo[(s_head + s_cnt) % NTASK] = id[4:0];
      s_cnt++;
    end
  endtask

  function automatic int unsigned best_level_one();
    int unsigned b;
    b = 0;
    for (int i = 0; i < NTASK; i++) begin
      if (!s_l1[i]) continue;
      if (b == 0 || s_prio[i] < s_prio[b-1] ||
          (s_prio[i] == s_prio[b-1] && s_arr[i] < s_arr[b-1]))
        b = i + 1;
    end
    return b;
  endfunction

  // Advance the shadow scheduler by one item and return its result
  task automatic schedule_item(input logic op, input logic [4:0] id, input logic [7:0] pr,
                               input logic [15:0] bu, output sched_result_t r);
    int unsigned t;
    r = '0;
    if (op == tlprs_pkg::OP_ARRIVE) begin
      if (id == 0 || id > NTASK || bu == 0 || s_l1[(id-1) % NTASK] || queued_rr(id) ||
          (s_lvl == tlprs_pkg::LVL_RR && s_run == id)) begin
        r.status = tlprs_pkg::ST_REJECT;
      end else begin
        s_prio[id-1] = pr;
        s_remain[id-1] = bu;
        s_orig[id-1] = bu;
        s_wait[id-1] = 0;
        s_arr[id-1] = s_now;
        s_l1[id-1] = 1'b1;
        if (s_best == 0 || pr < s_prio[s_best-1]) s_best = id;
      end
      r.run_id = s_run[4:0];
      r.run_lvl = s_lvl[1:0];
    end else begin
      // resolve new arrivals
      if (s_best != 0) begin
        if (s_lvl == tlprs_pkg::LVL_RR) begin
          rr_push(s_run);
          s_run = 0; s_lvl = 0; s_slice = 0;
        end
        if (s_lvl == tlprs_pkg::LVL_PRIO) begin
          if (s_prio[s_best-1] < s_prio[s_run-1]) begin
            s_l1[s_run-1] = 1'b0;
            rr_push(s_run);
            s_run = s_best;
          end
        end else begin
          s_run = s_best; s_lvl = tlprs_pkg::LVL_PRIO;
        end
        s_best = 0;
      end
      if (s_lvl == 0 && s_l1 != 0) begin
        s_run = best_level_one(); s_lvl = tlprs_pkg::LVL_PRIO;
      end
      if (s_lvl == 0 && s_cnt != 0) begin
        s_run = s_fifo[s_head % NTASK];
        s_head = (s_head + 1) % NTASK;
        s_cnt--;
        s_lvl = tlprs_pkg::LVL_RR; s_slice = 0;
      end
      s_now++;
      if (s_lvl == 0 || s_run == 0 || s_run > NTASK) begin
        s_run = 0; s_lvl = 0;
        r.status = tlprs_pkg::ST_IDLE_TCK;
      end else begin
        r.run_id = s_run[4:0];
        r.run_lvl = s_lvl[1:0];
        // everyone queued but not served waits one tick
        for (int i = 0; i < NTASK; i++)
          if (s_l1[i] && i + 1 != s_run) s_wait[i] = sat_inc(s_wait[i], 1);
        for (int k = 0; k < s_cnt; k++) begin
          t = s_fifo[(s_head + k) % NTASK];
          if (t >= 1 && t <= NTASK) s_wait[t-1] = sat_inc(s_wait[t-1], 1);
        end
        t = s_run - 1;
        if (s_remain[t] != 0) s_remain[t]--;
        if (s_remain[t] == 0) begin
          r.fin = 1'b1;
          r.fin_id = s_run[4:0];
          r.fin_wait = s_wait[t];
          r.fin_turn = sat_inc({16'd0, s_orig[t]}, s_wait[t]);
          if (s_lvl == tlprs_pkg::LVL_PRIO) begin
            s_l1[t] = 1'b0;
            s_run = best_level_one();
            s_lvl = s_run != 0 ? tlprs_pkg::LVL_PRIO : tlprs_pkg::LVL_IDLE;
          end else begin
            s_run = 0; s_lvl = 0;
          end
          s_slice = 0;
        end else if (s_lvl == tlprs_pkg::LVL_RR) begin
          s_slice = (s_slice + 1) & 8'hFF;
          if (s_slice >= s_quantum) begin
            rr_push(s_run);
            s_run = 0; s_lvl = 0; s_slice = 0;
          end
        end
      end
    end
    r.now = s_now;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    sched_result_t e;
    if (rst_ni && done_o) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (finished_o) n_finished++;
        if (status_o != e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); fails++;
        end
        if (running_id_o != e.run_id) begin
          $error("running_id exp %0d got %0d", e.run_id, running_id_o); fails++;
        end
        if (running_level_o != e.run_lvl) begin
          $error("running_level exp %0d got %0d", e.run_lvl, running_level_o); fails++;
        end
        if (finished_o != e.fin) begin
          $error("finished exp %0d got %0d", e.fin, finished_o); fails++;
        end
        if (finished_id_o != e.fin_id) begin
          $error("finished_id exp %0d got %0d", e.fin_id, finished_id_o); fails++;
        end
        if (finished_wait_o != e.fin_wait) begin
          $error("finished_wait exp %0d got %0d", e.fin_wait, finished_wait_o); fails++;
        end
        if (finished_turnaround_o != e.fin_turn) begin
          $error("finished_turnaround exp %0d got %0d", e.fin_turn,
                 finished_turnaround_o);
          fails++;
        end
        if (current_time_o != e.now) begin
          $error("current_time exp %0d got %0d", e.now, current_time_o); fails++;
        end
      end
    end
  end

  // Present one item and hold it until the block takes it
  task automatic send_item(logic op, logic [4:0] id, logic [7:0] pr, logic [15:0] bu,
                           logic fixed, logic [1:0] st);
    sched_result_t r;
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    task_id_i <= id;
    task_priority_i <= pr;
    task_burst_i <= bu;
    do @(posedge clk_i); while (busy);
    schedule_item(op, id, pr, bu, r);
    if (fixed) r.status = st;
    if (r.status == tlprs_pkg::ST_REJECT) n_rejects++;
    pending_results.push_back(r);
    n_items++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * NTASK + 12) @(posedge clk_i);
  endtask

  task automatic write_quantum(logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    s_quantum = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_items(int count);
    logic       op;
    logic [4:0] id;
    logic [7:0] pr;
    logic [15:0] bu;
    int sel;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 99) < 58) ? tlprs_pkg::OP_TICK : tlprs_pkg::OP_ARRIVE;
      sel = $urandom_range(0, 99);
      id = (sel < 90) ? 5'($urandom_range(1, NTASK)) :
           (sel < 94) ? 5'd0 : 5'($urandom_range(NTASK + 1, 31));
      pr = ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      sel = $urandom_range(0, 99);
      bu = (sel < 85) ? 16'($urandom_range(1, 8)) :
           (sel < 98) ? 16'($urandom_range(1, 40)) : 16'd0;
      send_item(op, id, pr, bu, 1'b0, tlprs_pkg::ST_OK);
    end
  endtask

  directed_item_t directed_items[25];
  logic [7:0] quanta[6];

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    operation_i = tlprs_pkg::OP_TICK;
    task_id_i = '0;
    task_priority_i = '0;
    task_burst_i = '0;
    for (int i = 0; i < NTASK; i++) begin
      s_prio[i] = 0; s_remain[i] = 0; s_orig[i] = 0;
      s_wait[i] = 0; s_arr[i] = 0; s_fifo[i] = 0;
    end
    s_l1 = '0; s_head = 0; s_cnt = 0; s_run = 0; s_lvl = 0;
    s_slice = 0; s_best = 0; s_now = 0; s_quantum = tlprs_pkg::QUANTUM_RESET;

    // empty tick, illegal ids and burst, ties, preemption, long task
    directed_items = '{
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b1, tlprs_pkg::ST_IDLE_TCK},
      '{tlprs_pkg::OP_ARRIVE, 5'd0,  8'd5,   16'd5,    1'b1, tlprs_pkg::ST_REJECT},
      '{tlprs_pkg::OP_ARRIVE, 5'd17, 8'd5,   16'd5,    1'b1, tlprs_pkg::ST_REJECT},
      '{tlprs_pkg::OP_ARRIVE, 5'd31, 8'd255, 16'hFFFF, 1'b1, tlprs_pkg::ST_REJECT},
      '{tlprs_pkg::OP_ARRIVE, 5'd1,  8'd8,   16'd0,    1'b1, tlprs_pkg::ST_REJECT},
      '{tlprs_pkg::OP_ARRIVE, 5'd1,  8'd200, 16'd3,    1'b1, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_ARRIVE, 5'd1,  8'd10,  16'd3,    1'b1, tlprs_pkg::ST_REJECT},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_ARRIVE, 5'd2,  8'd100, 16'd2,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_ARRIVE, 5'd3,  8'd100, 16'd1,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_ARRIVE, 5'd16, 8'd255, 16'hFFFF, 1'b1, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_ARRIVE, 5'd5,  8'd0,   16'd1,    1'b1, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_ARRIVE, 5'd5,  8'd0,   16'd2,    1'b1, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK},
      '{tlprs_pkg::OP_TICK,   5'd0,  8'd0,   16'd0,    1'b0, tlprs_pkg::ST_OK}
    };
    quanta = '{8'd1, 8'd255, 8'd0, 8'd2, 8'($urandom_range(3, 254)), 8'd4};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_items[i])
      send_item(directed_items[i].op, directed_items[i].id, directed_items[i].prio,
                directed_items[i].burst, directed_items[i].fixed, directed_items[i].status);
    random_items(150);

    // one phase per quantum setting; last phase runs without gaps
    foreach (quanta[p]) begin
      drain();
      write_quantum(quanta[p]);
      if (p == 5) gaps_on = 0;
      random_items(125);
    end

    drain();
    $display("items %0d (rejected %0d), results %0d, completions %0d, 7 quantum settings",
             n_items, n_rejects, n_results, n_finished);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/tlprs_pkg.sv
rtl/core/two_level_priority_rr_scheduler_core.sv
test/testbench.sv
